/* design/apsp_pkg.sv */
// apsp_pkg: shared types, constants and helper functions for the all-pairs
// shortest path block. No dependencies; every other design file uses it.
package apsp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int DIST_W   = 32;
  localparam int VCNT_W   = 7;
  localparam int VERTEX_W = 6;
  localparam int WEIGHT_W = 16;

  // distances at or above this value mean no path
  localparam logic signed [DIST_W-1:0] INF_VALUE = 32'sd99999;
  localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_RUN   = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE,
    ST_ROW_RD,
    ST_ROW_WAIT,
    ST_COL,
    ST_DRAIN,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                     write_en;
    logic signed [DIST_W-1:0] value;
  } relax_res_t;

  function automatic logic is_inf(input logic signed [DIST_W-1:0] v);
    return v >= INF_VALUE;
  endfunction

  function automatic logic signed [DIST_W-1:0] sat_add(
    input logic signed [DIST_W-1:0] a,
    input logic signed [DIST_W-1:0] b
  );
    logic signed [DIST_W:0] s;
    logic signed [DIST_W-1:0] r;
    s = {a[DIST_W-1], a} + {b[DIST_W-1], b};
    if (s[DIST_W] != s[DIST_W-1]) begin
      r = s[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      r = s[DIST_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/apsp_mem.sv */
// apsp_mem: distance matrix storage, one write port and two read ports,
// read data registered. Uses apsp_pkg.
module apsp_mem #(
  parameter int DEPTH = apsp_pkg::MAX_VERTICES_DEF * apsp_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(DEPTH)-1:0]            waddr,
  input  logic signed [apsp_pkg::DIST_W-1:0]  wdata,
  input  logic                                re_a,
  input  logic [$clog2(DEPTH)-1:0]            raddr_a,
  input  logic                                re_b,
  input  logic [$clog2(DEPTH)-1:0]            raddr_b,
  output logic signed [apsp_pkg::DIST_W-1:0]  rdata_a_r,
  output logic signed [apsp_pkg::DIST_W-1:0]  rdata_b_r
);

  logic signed [apsp_pkg::DIST_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a_r <= mem_r[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem_r[raddr_b];
    end
  end

endmodule

/* design/apsp_relax.sv */
// apsp_relax: one relaxation step, saturating leg sum and compare against
// the current distance. Uses apsp_pkg.
module apsp_relax (
  input  logic signed [apsp_pkg::DIST_W-1:0] ik,
  input  logic signed [apsp_pkg::DIST_W-1:0] kj,
  input  logic signed [apsp_pkg::DIST_W-1:0] ij,
  output apsp_pkg::relax_res_t               res
);

  logic signed [apsp_pkg::DIST_W-1:0] sum;

  always_comb begin
    sum = apsp_pkg::sat_add(ik, kj);
    // an infinite second leg is skipped; the first leg is checked per row
    res.write_en = !apsp_pkg::is_inf(kj) && (sum < ij);
    res.value    = sum;
  end

endmodule

/* design/apsp_ctrl.sv */
// apsp_ctrl: sequencer for clear, edge load, relaxation and result scan,
// plus the result register. Uses apsp_pkg and apsp_relax.
module apsp_ctrl #(
  parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic [apsp_pkg::VCNT_W-1:0]                       vertex_count,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [1:0]                                        in_action,
  input  logic [apsp_pkg::VERTEX_W-1:0]                     in_source_vertex,
  input  logic [apsp_pkg::VERTEX_W-1:0]                     in_dest_vertex,
  input  logic signed [apsp_pkg::WEIGHT_W-1:0]              in_edge_weight,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic                                              out_cycle_found,
  output logic                                              out_no_path,
  output logic signed [apsp_pkg::DIST_W-1:0]                out_min_distance,
  output logic                                              mem_we,
  output logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]      mem_waddr,
  output logic signed [apsp_pkg::DIST_W-1:0]                mem_wdata,
  output logic                                              mem_re_a,
  output logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]      mem_raddr_a,
  output logic                                              mem_re_b,
  output logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]      mem_raddr_b,
  input  logic signed [apsp_pkg::DIST_W-1:0]                mem_rdata_a,
  input  logic signed [apsp_pkg::DIST_W-1:0]                mem_rdata_b
);

  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int RW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int DW = apsp_pkg::DIST_W;
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_VERTICES);
  localparam logic [RW-1:0] LAST_IDX   = RW'(MAX_VERTICES - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] r, input logic [AW-1:0] c);
    return r * ROW_STRIDE + c;
  endfunction

  apsp_pkg::state_t state_r, state_nxt;
  logic [RW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [NW-1:0] n_r;
  logic [NW-1:0] n_cfg;
  logic signed [DW-1:0] ik_r;
  logic          p_valid_r;
  logic [AW-1:0] p_addr_r;
  logic          s_valid_r, s_diag_r;
  logic          cyc_r, found_r;
  logic signed [DW-1:0] best_r;
  logic          e_ok_r;
  logic [AW-1:0] e_addr_r;
  logic signed [DW-1:0] e_wdata_r;
  logic          out_valid_r, out_cycle_r, out_no_path_r;
  logic signed [DW-1:0] out_min_r;

  logic take, out_free;
  logic i_last_n, j_last_n, k_last_n, i_last_m, j_last_m, run_end;
  apsp_pkg::relax_res_t relax_res;

  apsp_relax u_relax (
    .ik  (ik_r),
    .kj  (mem_rdata_a),
    .ij  (mem_rdata_b),
    .res (relax_res)
  );

  assign in_ready = (state_r == apsp_pkg::ST_IDLE);
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign i_last_n = (NW'(i_r) == n_r - NW'(1));
  assign j_last_n = (NW'(j_r) == n_r - NW'(1));
  assign k_last_n = (NW'(k_r) == n_r - NW'(1));
  assign i_last_m = (i_r == LAST_IDX);
  assign j_last_m = (j_r == LAST_IDX);
  assign run_end  = i_last_n && k_last_n;

  // vertex count clamped to 1..MAX_VERTICES
  always_comb begin
    if (int'(vertex_count) > MAX_VERTICES) begin
      n_cfg = NW'(MAX_VERTICES);
    end else if (vertex_count == '0) begin
      n_cfg = NW'(1);
    end else begin
      n_cfg = NW'(vertex_count);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apsp_pkg::ST_CLEAR: begin
        if (i_last_m && j_last_m) state_nxt = apsp_pkg::ST_IDLE;
      end
      apsp_pkg::ST_IDLE: begin
        if (take) begin
          unique case (in_action)
            apsp_pkg::ACT_CLEAR: state_nxt = apsp_pkg::ST_CLEAR;
            apsp_pkg::ACT_EDGE:  state_nxt = apsp_pkg::ST_EDGE;
            apsp_pkg::ACT_RUN:   state_nxt = apsp_pkg::ST_ROW_RD;
            default:             state_nxt = apsp_pkg::ST_IDLE;
          endcase
        end
      end
      apsp_pkg::ST_EDGE:   state_nxt = apsp_pkg::ST_IDLE;
      apsp_pkg::ST_ROW_RD: state_nxt = apsp_pkg::ST_ROW_WAIT;
      apsp_pkg::ST_ROW_WAIT: begin
        if (!apsp_pkg::is_inf(mem_rdata_a)) begin
          state_nxt = apsp_pkg::ST_COL;
        end else begin
          state_nxt = run_end ? apsp_pkg::ST_SCAN : apsp_pkg::ST_ROW_RD;
        end
      end
      apsp_pkg::ST_COL: begin
        if (j_last_n) state_nxt = apsp_pkg::ST_DRAIN;
      end
      apsp_pkg::ST_DRAIN: begin
        state_nxt = run_end ? apsp_pkg::ST_SCAN : apsp_pkg::ST_ROW_RD;
      end
      apsp_pkg::ST_SCAN: begin
        if (i_last_n && j_last_n) state_nxt = apsp_pkg::ST_SCAN_END;
      end
      apsp_pkg::ST_SCAN_END: state_nxt = apsp_pkg::ST_DONE;
      apsp_pkg::ST_DONE: begin
        if (out_free) state_nxt = apsp_pkg::ST_IDLE;
      end
      default: state_nxt = apsp_pkg::ST_IDLE;
    endcase
  end

  // counters and memory control
  always_comb begin
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    mem_we      = 1'b0;
    mem_waddr   = cell_addr(AW'(i_r), AW'(j_r));
    mem_wdata   = '0;
    mem_re_a    = 1'b0;
    mem_raddr_a = cell_addr(AW'(i_r), AW'(j_r));
    mem_re_b    = 1'b0;
    mem_raddr_b = cell_addr(AW'(i_r), AW'(j_r));
    unique case (state_r)
      apsp_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = (i_r == j_r) ? '0 : apsp_pkg::INF_VALUE;
        j_nxt     = j_last_m ? '0 : j_r + RW'(1);
        if (j_last_m) i_nxt = i_last_m ? '0 : i_r + RW'(1);
      end
      apsp_pkg::ST_IDLE: begin
        if (take) begin
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
        end
      end
      apsp_pkg::ST_EDGE: begin
        mem_we    = e_ok_r;
        mem_waddr = e_addr_r;
        mem_wdata = e_wdata_r;
      end
      apsp_pkg::ST_ROW_RD: begin
        mem_re_a    = 1'b1;
        mem_raddr_a = cell_addr(AW'(i_r), AW'(k_r));
      end
      apsp_pkg::ST_ROW_WAIT, apsp_pkg::ST_DRAIN: begin
        j_nxt = '0;
        // skipped or finished row: step to the next row, or next pivot
        if (state_r == apsp_pkg::ST_DRAIN || apsp_pkg::is_inf(mem_rdata_a)) begin
          if (i_last_n) begin
            i_nxt = '0;
            k_nxt = k_r + RW'(1);
          end else begin
            i_nxt = i_r + RW'(1);
          end
        end
      end
      apsp_pkg::ST_COL: begin
        mem_re_a    = 1'b1;
        mem_raddr_a = cell_addr(AW'(k_r), AW'(j_r));
        mem_re_b    = 1'b1;
        j_nxt       = j_r + RW'(1);
      end
      apsp_pkg::ST_SCAN: begin
        mem_re_a = 1'b1;
        if (j_last_n) begin
          j_nxt = '0;
          i_nxt = i_r + RW'(1);
        end else begin
          j_nxt = j_r + RW'(1);
        end
      end
      apsp_pkg::ST_SCAN_END, apsp_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
    // write-back of the relaxation pipeline
    if (p_valid_r && relax_res.write_en) begin
      mem_we    = 1'b1;
      mem_waddr = p_addr_r;
      mem_wdata = relax_res.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apsp_pkg::ST_CLEAR;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      p_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
      p_valid_r <= (state_r == apsp_pkg::ST_COL);
      s_valid_r <= (state_r == apsp_pkg::ST_SCAN);
      if (state_r == apsp_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_addr_r <= cell_addr(AW'(i_r), AW'(j_r));
    s_diag_r <= (i_r == j_r);
    if (take) begin
      n_r       <= n_cfg;
      e_ok_r    <= (int'(in_source_vertex) < MAX_VERTICES) &&
                   (int'(in_dest_vertex) < MAX_VERTICES);
      e_addr_r  <= cell_addr(AW'(in_source_vertex), AW'(in_dest_vertex));
      e_wdata_r <= {{(DW - apsp_pkg::WEIGHT_W){in_edge_weight[apsp_pkg::WEIGHT_W-1]}},
                    in_edge_weight};
      cyc_r     <= 1'b0;
      found_r   <= 1'b0;
      best_r    <= '0;
    end
    if (state_r == apsp_pkg::ST_ROW_WAIT) begin
      ik_r <= mem_rdata_a;
    end
    // scan: diagonal sign check and running off-diagonal minimum
    if (s_valid_r) begin
      if (s_diag_r) begin
        if (mem_rdata_a[DW-1]) cyc_r <= 1'b1;
      end else if (!apsp_pkg::is_inf(mem_rdata_a) && (!found_r || mem_rdata_a < best_r)) begin
        best_r  <= mem_rdata_a;
        found_r <= 1'b1;
      end
    end
    if (state_r == apsp_pkg::ST_DONE && out_free) begin
      out_cycle_r   <= cyc_r;
      out_no_path_r <= !cyc_r && !found_r;
      out_min_r     <= (!cyc_r && found_r) ? best_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cycle_found  = out_cycle_r;
  assign out_no_path      = out_no_path_r;
  assign out_min_distance = out_min_r;

endmodule

/* design/all_pairs_shortest_path.sv */
// all_pairs_shortest_path: top level, vertex count register, sequencer and
// distance matrix memory. Uses apsp_pkg, apsp_ctrl and apsp_mem.
//
//   channel   ports                                   direction
//   in        in_valid/in_ready, in_action, vertices  item in
//   out       out_valid/out_ready, flags, distance    result out
//   cfg       cfg_valid/cfg_ready, cfg_vertex_count   register write
//
// reset and clear items sweep all MAX_VERTICES^2 matrix entries (4096 by
// default), one entry a cycle, with in_ready low. an edge item is registered,
// then written. a run with n vertices relaxes one matrix entry per cycle within
// a row, through the memory's single write port, then scans the n*n entries and
// registers the result. a pending result only stalls the end of a run.
module all_pairs_shortest_path #(
  parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_action,
  input  logic [apsp_pkg::VERTEX_W-1:0]        in_source_vertex,
  input  logic [apsp_pkg::VERTEX_W-1:0]        in_dest_vertex,
  input  logic signed [apsp_pkg::WEIGHT_W-1:0] in_edge_weight,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_cycle_found,
  output logic                                 out_no_path,
  output logic signed [apsp_pkg::DIST_W-1:0]   out_min_distance,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [apsp_pkg::VCNT_W-1:0]          cfg_vertex_count
);

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);

  logic [apsp_pkg::VCNT_W-1:0] vcount_r;
  logic                               mem_we, mem_re_a, mem_re_b;
  logic [AW-1:0]                      mem_waddr, mem_raddr_a, mem_raddr_b;
  logic signed [apsp_pkg::DIST_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= apsp_pkg::VCNT_RESET;
    end else if (cfg_valid) begin
      vcount_r <= cfg_vertex_count;
    end
  end

  apsp_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .vertex_count     (vcount_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_source_vertex (in_source_vertex),
    .in_dest_vertex   (in_dest_vertex),
    .in_edge_weight   (in_edge_weight),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cycle_found  (out_cycle_found),
    .out_no_path      (out_no_path),
    .out_min_distance (out_min_distance),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re_a         (mem_re_a),
    .mem_raddr_a      (mem_raddr_a),
    .mem_re_b         (mem_re_b),
    .mem_raddr_b      (mem_raddr_b),
    .mem_rdata_a      (mem_rdata_a),
    .mem_rdata_b      (mem_rdata_b)
  );

  apsp_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk       (clk),
    .we        (mem_we),
    .waddr     (mem_waddr),
    .wdata     (mem_wdata),
    .re_a      (mem_re_a),
    .raddr_a   (mem_raddr_a),
    .re_b      (mem_re_b),
    .raddr_b   (mem_raddr_b),
    .rdata_a_r (mem_rdata_a),
    .rdata_b_r (mem_rdata_b)
  );

`ifndef SYNTHESIS
  // the sequencer never reads an entry in the cycle it is being written
  a_no_rw_a: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re_a) |-> (mem_raddr_a != mem_waddr))
    else $error("read port a collides with write");
  a_no_rw_b: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re_b) |-> (mem_raddr_b != mem_waddr))
    else $error("read port b collides with write");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_cycle_found && out_no_path))
    else $error("cycle and no-path flags both set");
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_cycle_found || out_no_path)) |-> (out_min_distance == '0))
    else $error("distance not zero with a flag set");
`endif

endmodule
